// ===== rtl/wdc_pkg.sv =====
// Shared types, constants and the control store of the working day counter.
package wdc_pkg;

   localparam int MASK_W  = 7;
   localparam int COUNT_W = 22;
   localparam int DAYN_W  = 23;   // day number, difference and running total
   localparam int UPC_W   = 5;

   localparam logic [MASK_W-1:0]  MASK_RESET = 7'd96;   // Friday and Saturday
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'd4194303;

   // floor(x * RECIP_100 >> 16) == x / 25 for x below 4681, so y / 100 from x = y / 4
   localparam logic [15:0] RECIP_100 = 16'd2622;
   // floor(x * RECIP_7 >> 26) == x / 7 for every 23-bit x
   localparam logic [23:0] RECIP_7   = 24'd9586981;
   localparam logic [14:0] YEAR_BIAS = 15'd400;
   localparam logic [23:0] DAYS_YEAR = 24'd365;
   localparam logic [3:0]  MONTH_JAN = 4'd1;
   localparam logic [3:0]  MONTH_FEB = 4'd2;
   localparam logic [3:0]  MONTH_DEC = 4'd12;

   // multiplier operand selects
   localparam logic [2:0] MUL_NONE  = 3'd0;
   localparam logic [2:0] MUL_Y4    = 3'd1;
   localparam logic [2:0] MUL_YY4   = 3'd2;
   localparam logic [2:0] MUL_YY365 = 3'd3;
   localparam logic [2:0] MUL_N7    = 3'd4;
   localparam logic [2:0] MUL_S7    = 3'd5;
   localparam logic [2:0] MUL_QPW   = 3'd6;

   // datapath operations
   localparam logic [3:0] OP_NOP    = 4'd0;
   localparam logic [3:0] OP_YQ     = 4'd1;
   localparam logic [3:0] OP_CHECK  = 4'd2;
   localparam logic [3:0] OP_ADD365 = 4'd3;
   localparam logic [3:0] OP_CENT   = 4'd4;
   localparam logic [3:0] OP_DIFF   = 4'd5;
   localparam logic [3:0] OP_Q7     = 4'd6;
   localparam logic [3:0] OP_MODS   = 4'd7;
   localparam logic [3:0] OP_TOTAL  = 4'd8;
   localparam logic [3:0] OP_STEP   = 4'd9;

   // sequencing conditions
   localparam logic [1:0] COND_NEXT = 2'd0;
   localparam logic [1:0] COND_SKIP = 2'd1;
   localparam logic [1:0] COND_LOOP = 2'd2;
   localparam logic [1:0] COND_END  = 2'd3;

   localparam logic [UPC_W-1:0] STEP_LOOP = 5'd15;
   localparam logic [UPC_W-1:0] STEP_END  = 5'd16;

   typedef struct packed {
      logic [4:0]  start_day;
      logic [3:0]  start_month;
      logic [13:0] start_year;
      logic [4:0]  end_day;
      logic [3:0]  end_month;
      logic [13:0] end_year;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] working_days;
      logic               date_invalid;
   } rsp_type;

   typedef struct packed {
      logic             sel_end;
      logic [2:0]       mul_sel;
      logic [3:0]       alu_op;
      logic [1:0]       cond;
      logic [UPC_W-1:0] target;
   } ctrl_word_type;

   function automatic logic [4:0] month_len(input logic [3:0] m);
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     month_len = 5'd30;
         4'd2:                                        month_len = 5'd28;
         default:                                     month_len = 5'd0;
      endcase
   endfunction

   // days before the month in a year that starts in March
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      case (m)
         4'd3:    month_offset = 9'd0;
         4'd4:    month_offset = 9'd31;
         4'd5:    month_offset = 9'd61;
         4'd6:    month_offset = 9'd92;
         4'd7:    month_offset = 9'd122;
         4'd8:    month_offset = 9'd153;
         4'd9:    month_offset = 9'd184;
         4'd10:   month_offset = 9'd214;
         4'd11:   month_offset = 9'd245;
         4'd12:   month_offset = 9'd275;
         4'd1:    month_offset = 9'd306;
         4'd2:    month_offset = 9'd337;
         default: month_offset = 9'd0;
      endcase
   endfunction

   function automatic ctrl_word_type ucode(input logic [UPC_W-1:0] upc);
      case (upc)
         // start date to day number
         5'd0:    ucode = '{1'b0, MUL_Y4,    OP_NOP,    COND_NEXT, 5'd0};
         5'd1:    ucode = '{1'b0, MUL_YY4,   OP_YQ,     COND_NEXT, 5'd0};
         5'd2:    ucode = '{1'b0, MUL_YY365, OP_CHECK,  COND_NEXT, 5'd0};
         5'd3:    ucode = '{1'b0, MUL_NONE,  OP_ADD365, COND_NEXT, 5'd0};
         5'd4:    ucode = '{1'b0, MUL_NONE,  OP_CENT,   COND_NEXT, 5'd0};
         // end date to day number
         5'd5:    ucode = '{1'b1, MUL_Y4,    OP_NOP,    COND_NEXT, 5'd0};
         5'd6:    ucode = '{1'b1, MUL_YY4,   OP_YQ,     COND_NEXT, 5'd0};
         5'd7:    ucode = '{1'b1, MUL_YY365, OP_CHECK,  COND_NEXT, 5'd0};
         5'd8:    ucode = '{1'b1, MUL_NONE,  OP_ADD365, COND_NEXT, 5'd0};
         5'd9:    ucode = '{1'b1, MUL_NONE,  OP_CENT,   COND_NEXT, 5'd0};
         // span, whole weeks and leftover days
         5'd10:   ucode = '{1'b0, MUL_NONE,  OP_DIFF,   COND_SKIP, STEP_END};
         5'd11:   ucode = '{1'b0, MUL_N7,    OP_NOP,    COND_NEXT, 5'd0};
         5'd12:   ucode = '{1'b0, MUL_S7,    OP_Q7,     COND_NEXT, 5'd0};
         5'd13:   ucode = '{1'b0, MUL_QPW,   OP_MODS,   COND_NEXT, 5'd0};
         5'd14:   ucode = '{1'b0, MUL_NONE,  OP_TOTAL,  COND_NEXT, 5'd0};
         5'd15:   ucode = '{1'b0, MUL_NONE,  OP_STEP,   COND_LOOP, STEP_LOOP};
         5'd16:   ucode = '{1'b0, MUL_NONE,  OP_NOP,    COND_END,  5'd0};
         default: ucode = '{1'b0, MUL_NONE,  OP_NOP,    COND_END,  5'd0};
      endcase
   endfunction

endpackage

// ===== rtl/working_day_counter.sv =====
// A result takes longer the more leftover days the loop steps through; a word with an
// invalid date or an end not after the start skips the week and leftover-day steps.
// Throughput: one word at a time, set by the microprogram and its one multiplier;
// a new word is taken while the previous result still waits on a stalled output.
// Reset (synchronous): sequencer idle, no result pending, weekend mask Friday and
// Saturday.
module working_day_counter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  wdc_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output wdc_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [wdc_pkg::MASK_W-1:0]   csr_wr_data
);

   localparam int DW = wdc_pkg::DAYN_W;

   // control state
   logic                        busy_ff, busy_in;
   logic [wdc_pkg::UPC_W-1:0]   upc_ff, upc_in;
   logic [wdc_pkg::MASK_W-1:0]  mask_ff;
   logic                        rsp_valid_ff, rsp_valid_in;

   // datapath
   wdc_pkg::req_type            req_ff;
   wdc_pkg::rsp_type            rsp_ff, rsp_in;
   logic [46:0]                 prod_ff, prod_in;
   logic [7:0]                  ylq_ff, ylq_in;
   logic [7:0]                  yyq_ff, yyq_in;
   logic [DW-1:0]               acc_ff, acc_in;
   logic [DW-1:0]               s_ff, s_in;
   logic [DW-1:0]               e_ff, e_in;
   logic [DW-1:0]               n_ff, n_in;
   logic [20:0]                 q7_ff, q7_in;
   logic [2:0]                  rem_ff, rem_in;
   logic [2:0]                  dow_ff, dow_in;
   logic [DW-1:0]               total_ff, total_in;
   logic                        invalid_ff, invalid_in;

   wdc_pkg::ctrl_word_type      cw;
   logic                        accept;
   logic                        out_free;

   logic [4:0]                  d;
   logic [3:0]                  m;
   logic [13:0]                 y;
   logic                        early;
   logic [14:0]                 yy;
   logic [DW-1:0]               sp3;
   logic [DW-1:0]               opa;
   logic [23:0]                 opb;
   logic [2:0]                  per_week;
   logic [14:0]                 century_y;
   logic                        y_is_cent;
   logic                        leap;
   logic [4:0]                  mlen;
   logic                        date_ok;
   logic [7:0]                  cent_corr;
   logic [wdc_pkg::COUNT_W-1:0] count_sat;

   assign cw        = wdc_pkg::ucode(upc_ff);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // date picked by the current control word
   assign d = cw.sel_end ? req_ff.end_day   : req_ff.start_day;
   assign m = cw.sel_end ? req_ff.end_month : req_ff.start_month;
   assign y = cw.sel_end ? req_ff.end_year  : req_ff.start_year;

   assign early = (m <= wdc_pkg::MONTH_FEB);
   assign yy    = {1'b0, y} + wdc_pkg::YEAR_BIAS - {14'd0, early};
   assign sp3   = s_ff + DW'(3);

   // leap test from y / 100 held in ylq_ff
   assign century_y = 15'(ylq_ff) * 15'd100;
   assign y_is_cent = ({1'b0, y} == century_y);
   assign leap      = ((y[1:0] == 2'd0) && !y_is_cent) || (y_is_cent && (ylq_ff[1:0] == 2'd0));
   assign mlen      = (m == wdc_pkg::MONTH_FEB) ? (leap ? 5'd29 : 5'd28)
                                                : wdc_pkg::month_len(m);
   assign date_ok   = (m >= wdc_pkg::MONTH_JAN) && (m <= wdc_pkg::MONTH_DEC) &&
                      (d != 5'd0) && (d <= mlen);

   // -yy/100 + yy/400
   assign cent_corr = yyq_ff - {2'b00, yyq_ff[7:2]};

   assign count_sat = total_ff[DW-1] ? wdc_pkg::COUNT_MAX : total_ff[wdc_pkg::COUNT_W-1:0];

   always_comb begin
      per_week = 3'd0;
      for (int i = 0; i < wdc_pkg::MASK_W; i++) begin
         per_week = per_week + 3'(!mask_ff[i]);
      end
   end

   // shared multiplier
   always_comb begin
      case (cw.mul_sel)
         wdc_pkg::MUL_Y4: begin
            opa = DW'(y[13:2]);
            opb = 24'(wdc_pkg::RECIP_100);
         end
         wdc_pkg::MUL_YY4: begin
            opa = DW'(yy[14:2]);
            opb = 24'(wdc_pkg::RECIP_100);
         end
         wdc_pkg::MUL_YY365: begin
            opa = DW'(yy);
            opb = wdc_pkg::DAYS_YEAR;
         end
         wdc_pkg::MUL_N7: begin
            opa = n_ff;
            opb = wdc_pkg::RECIP_7;
         end
         wdc_pkg::MUL_S7: begin
            opa = sp3;
            opb = wdc_pkg::RECIP_7;
         end
         wdc_pkg::MUL_QPW: begin
            opa = DW'(q7_ff);
            opb = 24'(per_week);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      prod_in = 47'(opa) * 47'(opb);
   end

   // datapath operations
   always_comb begin
      ylq_in     = ylq_ff;
      yyq_in     = yyq_ff;
      acc_in     = acc_ff;
      s_in       = s_ff;
      e_in       = e_ff;
      n_in       = n_ff;
      q7_in      = q7_ff;
      rem_in     = rem_ff;
      dow_in     = dow_ff;
      total_in   = total_ff;
      invalid_in = invalid_ff;
      if (busy_ff) begin
         case (cw.alu_op)
            wdc_pkg::OP_YQ: begin
               ylq_in = prod_ff[23:16];
            end
            wdc_pkg::OP_CHECK: begin
               invalid_in = invalid_ff || !date_ok;
               yyq_in     = prod_ff[23:16];
               acc_in     = DW'(yy[14:2]) + DW'(wdc_pkg::month_offset(m)) + DW'(d) - DW'(1);
            end
            wdc_pkg::OP_ADD365: begin
               acc_in = acc_ff + prod_ff[DW-1:0];
            end
            wdc_pkg::OP_CENT: begin
               if (cw.sel_end) begin
                  e_in = acc_ff - DW'(cent_corr);
               end else begin
                  s_in = acc_ff - DW'(cent_corr);
               end
            end
            wdc_pkg::OP_DIFF: begin
               n_in = e_ff - s_ff;
            end
            wdc_pkg::OP_Q7: begin
               q7_in = prod_ff[46:26];
            end
            wdc_pkg::OP_MODS: begin
               // x - 7q is below 7 and equals x + q modulo 8
               rem_in = n_ff[2:0] + q7_ff[2:0];
               dow_in = sp3[2:0] + prod_ff[28:26];
            end
            wdc_pkg::OP_TOTAL: begin
               total_in = prod_ff[DW-1:0];
            end
            wdc_pkg::OP_STEP: begin
               if (rem_ff != 3'd0) begin
                  total_in = total_ff + DW'(!mask_ff[dow_ff]);
                  dow_in   = (dow_ff == 3'd6) ? 3'd0 : dow_ff + 3'd1;
                  rem_in   = rem_ff - 3'd1;
               end
            end
            default: begin
            end
         endcase
      end
      if (accept) begin
         total_in   = '0;
         invalid_in = 1'b0;
      end
   end

   // sequencer
   always_comb begin
      busy_in      = busy_ff;
      upc_in       = upc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (busy_ff) begin
         case (cw.cond)
            wdc_pkg::COND_NEXT: begin
               upc_in = upc_ff + wdc_pkg::UPC_W'(1);
            end
            wdc_pkg::COND_SKIP: begin
               upc_in = (invalid_ff || (e_ff <= s_ff)) ? cw.target
                                                       : upc_ff + wdc_pkg::UPC_W'(1);
            end
            wdc_pkg::COND_LOOP: begin
               upc_in = (rem_ff > 3'd1) ? cw.target : upc_ff + wdc_pkg::UPC_W'(1);
            end
            wdc_pkg::COND_END: begin
               // hold until the output register can take the word
               if (out_free) begin
                  busy_in                = 1'b0;
                  rsp_valid_in           = 1'b1;
                  rsp_in.working_days    = count_sat;
                  rsp_in.date_invalid    = invalid_ff;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end else if (accept) begin
         busy_in = 1'b1;
         upc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         upc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= wdc_pkg::MASK_RESET;
      end else begin
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_ff     <= rsp_in;
      prod_ff    <= prod_in;
      ylq_ff     <= ylq_in;
      yyq_ff     <= yyq_in;
      acc_ff     <= acc_in;
      s_ff       <= s_in;
      e_ff       <= e_in;
      n_ff       <= n_in;
      q7_ff      <= q7_in;
      rem_ff     <= rem_in;
      dow_ff     <= dow_in;
      total_ff   <= total_in;
      invalid_ff <= invalid_in;
   end

endmodule

// ===== rtl/wdc_checker.sv =====
// Port-level checks for the working day counter, bound to its top level.
module wdc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input wdc_pkg::rsp_type rsp_data
);

   // a bad date never carries a count
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.date_invalid) |-> (rsp_data.working_days == '0))
      else $error("invalid date with nonzero count");

   // a taken word keeps the input closed while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after accepting a word");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result dropped or changed");

endmodule

bind working_day_counter wdc_checker u_wdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/working_day_counter_test.sv =====
// Self-checking testbench for the working day counter: random and directed date pairs.
module working_day_counter_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 40;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   wdc_pkg::req_type                   req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   wdc_pkg::rsp_type                   rsp_data;
   logic                               csr_wr_en = 1'b0;
   logic [wdc_pkg::MASK_W-1:0]         csr_wr_data = '0;

   wdc_pkg::req_type                   pending_words[$];
   wdc_pkg::rsp_type                   expected_counts[$];
   logic [wdc_pkg::MASK_W-1:0]         weekend_model = wdc_pkg::MASK_RESET;
   int                                 sender_idle_pct = 0;
   int                                 receiver_stall_pct = 0;
   bit                                 hold_request = 1'b0;
   bit                                 hold_seen = 1'b0;
   int                                 hold_left = 0;
   int                                 mismatches = 0;
   int                                 quiet_cycles = 0;

   working_day_counter uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // calendar helpers
   function automatic bit is_leap(input int y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
   endfunction

   function automatic int days_in(input int m, input int y);
      case (m)
         2:          return is_leap(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:    return 31;
      endcase
   endfunction

   function automatic bit date_valid(input int d, input int m, input int y);
      if (m < 1 || m > 12 || d < 1) return 1'b0;
      return d <= days_in(m, y);
   endfunction

   // days since a fixed origin, counting years from March so leap days fall last
   function automatic longint day_index(input int d, input int m, input int y);
      longint shifted_year;
      longint shifted_month;
      shifted_year  = y + 400 - ((m <= 2) ? 1 : 0);
      shifted_month = (m <= 2) ? m + 9 : m - 3;
      return 365 * shifted_year + shifted_year / 4 - shifted_year / 100
             + shifted_year / 400 + (153 * shifted_month + 2) / 5 + d - 1;
   endfunction

   function automatic wdc_pkg::rsp_type count_working_days(
         input wdc_pkg::req_type w, input logic [wdc_pkg::MASK_W-1:0] mask);
      wdc_pkg::rsp_type r;
      longint  first;
      longint  last;
      longint  span;
      longint  total;
      int      weekday;
      int      per_week;
      r = '0;
      if (!date_valid(w.start_day, w.start_month, w.start_year) ||
          !date_valid(w.end_day, w.end_month, w.end_year)) begin
         r.date_invalid = 1'b1;
      end else begin
         first = day_index(w.start_day, w.start_month, w.start_year);
         last  = day_index(w.end_day, w.end_month, w.end_year);
         if (last > first) begin
            span     = last - first;
            weekday  = int'((first + 3) % 7);
            per_week = 7 - $countones(mask);
            total    = (span / 7) * per_week;
            for (int i = 0; i < span % 7; i++) begin
               if (!mask[(weekday + i) % 7]) total++;
            end
            r.working_days = (total > wdc_pkg::COUNT_MAX) ? wdc_pkg::COUNT_MAX
                                                          : total[wdc_pkg::COUNT_W-1:0];
         end
      end
      return r;
   endfunction

   function automatic wdc_pkg::req_type make_word(input int sd, input int sm, input int sy,
                                                  input int ed, input int em, input int ey);
      wdc_pkg::req_type w;
      w.start_day   = 5'(sd);
      w.start_month = 4'(sm);
      w.start_year  = 14'(sy);
      w.end_day     = 5'(ed);
      w.end_month   = 4'(em);
      w.end_year    = 14'(ey);
      return w;
   endfunction

   function automatic logic [wdc_pkg::MASK_W-1:0] random_mask();
      logic [31:0] bits;
      bits = $urandom();
      return bits[wdc_pkg::MASK_W-1:0];
   endfunction

   function automatic int pick_year();
      int special_years[9] = '{0, 1, 100, 400, 1900, 2000, 9999, 16000, 16383};
      case ($urandom_range(9))
         0:       return special_years[$urandom_range(8)];
         1:       return $urandom_range(10000, 16383);
         default: return $urandom_range(1, 9999);
      endcase
   endfunction

   function automatic wdc_pkg::req_type random_word();
      int          kind;
      int          sd, sm, sy, ed, em, ey;
      int          bad_months[4] = '{0, 13, 14, 15};
      logic [63:0] noise;
      kind = $urandom_range(99);
      sy   = pick_year();
      case ($urandom_range(3))
         0:       ey = sy;
         1:       ey = sy + $urandom_range(1);
         2:       ey = sy + $urandom_range(60);
         default: ey = pick_year();
      endcase
      if (ey > 16383) ey = 16383;
      sm = $urandom_range(1, 12);
      em = $urandom_range(1, 12);
      sd = $urandom_range(1, days_in(sm, sy));
      ed = $urandom_range(1, days_in(em, ey));
      if (kind < 8) begin
         ed = sd;
         em = sm;
         ey = sy;
      end else if (kind < 20) begin
         // land on or just past the end of a month, February most of all
         if ($urandom_range(1)) begin
            sm = $urandom_range(1) ? 2 : sm;
            sd = days_in(sm, sy) + $urandom_range(1);
         end else begin
            em = $urandom_range(1) ? 2 : em;
            ed = days_in(em, ey) + $urandom_range(1);
         end
      end else if (kind < 30) begin
         noise = {$urandom(), $urandom()};
         return noise[45:0];
      end else if (kind < 36) begin
         case ($urandom_range(3))
            0:       sm = bad_months[$urandom_range(3)];
            1:       em = bad_months[$urandom_range(3)];
            2:       sd = 0;
            default: ed = 0;
         endcase
      end
      return make_word(sd, sm, sy, ed, em, ey);
   endfunction

   // driver: hold a stalled word, take the next pending one after acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_counts.push_back(count_working_days(req_data, weekend_model));
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result word, then pick the next stall
   always @(posedge clock) begin
      wdc_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               mismatches++;
               $display("%0t: result word with nothing expected: days %0d invalid %0d",
                        $realtime, rsp_data.working_days, rsp_data.date_invalid);
            end else begin
               want = expected_counts.pop_front();
               if (rsp_data.working_days !== want.working_days) begin
                  mismatches++;
                  $display("%0t: working_days expected %0d actual %0d", $realtime,
                           want.working_days, rsp_data.working_days);
               end
               if (rsp_data.date_invalid !== want.date_invalid) begin
                  mismatches++;
                  $display("%0t: date_invalid expected %0d actual %0d", $realtime,
                           want.date_invalid, rsp_data.date_invalid);
               end
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (hold_request != hold_seen) begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   // watchdog: give up when work is outstanding and nothing moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (!req_valid && !rsp_valid && expected_counts.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic drain();
      @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_counts.size() != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic write_mask(input logic [wdc_pkg::MASK_W-1:0] mask);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mask;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      weekend_model = mask;
   endtask

   task automatic run_phase(input logic [wdc_pkg::MASK_W-1:0] mask, input int idle_pct,
                            input int stall_pct, input int count, input bit hold);
      drain();
      write_mask(mask);
      @(negedge clock);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      if (hold) hold_request = ~hold_request;
      for (int i = 0; i < count; i++) begin
         pending_words.push_back(random_word());
         // pause the sender now and then until every result is back
         if (i % 150 == 149) drain();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words under the reset mask
      pending_words.push_back(make_word(1, 1, 2024, 1, 1, 2025));
      pending_words.push_back(make_word(15, 6, 2023, 15, 6, 2023));
      pending_words.push_back(make_word(10, 3, 2023, 1, 3, 2023));
      pending_words.push_back(make_word(29, 2, 2024, 1, 3, 2024));
      pending_words.push_back(make_word(29, 2, 2023, 1, 3, 2023));
      pending_words.push_back(make_word(29, 2, 1900, 1, 3, 1900));
      pending_words.push_back(make_word(29, 2, 2000, 1, 3, 2100));
      pending_words.push_back(make_word(1, 4, 2023, 31, 4, 2023));
      pending_words.push_back(make_word(30, 2, 2024, 1, 3, 2024));
      pending_words.push_back(make_word(0, 5, 2023, 1, 6, 2023));
      pending_words.push_back(make_word(1, 0, 2023, 1, 6, 2023));
      pending_words.push_back(make_word(1, 1, 2023, 1, 13, 2023));
      pending_words.push_back(make_word(1, 15, 2023, 1, 1, 2024));
      pending_words.push_back(make_word(29, 2, 0, 1, 1, 1));
      pending_words.push_back(make_word(1, 1, 1, 31, 12, 9999));
      pending_words.push_back(make_word(1, 1, 0, 31, 12, 16383));
      pending_words.push_back(make_word(1, 1, 16383, 31, 12, 16383));
      pending_words.push_back(make_word(31, 12, 2023, 1, 1, 2024));
      pending_words.push_back(make_word(31, 1, 2023, 1, 2, 2023));
      pending_words.push_back(make_word(31, 15, 16383, 31, 15, 16383));
      pending_words.push_back(make_word(0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(5, 1, 2024, 12, 1, 2024));
      pending_words.push_back(make_word(31, 12, 9999, 1, 1, 1));

      run_phase(7'd0, 0, 0, 300, 1'b0);
      run_phase(7'd127, 55, 0, 200, 1'b0);
      run_phase(wdc_pkg::MASK_RESET, 0, 55, 350, 1'b1);
      run_phase(random_mask(), 0, 0, 50, 1'b0);
      run_phase(random_mask(), 38, 38, 400, 1'b0);
      run_phase(random_mask(), 38, 38, 400, 1'b0);
      drain();

      if (mismatches == 0 && expected_counts.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
